/* src/dtcw_pkg.sv */
// shared types, constants and helper functions for the date text checker
package dtcw_pkg;

  localparam int CHAR_W  = 8;
  localparam int DAY_W   = 7;
  localparam int MONTH_W = 7;
  localparam int YEAR_W  = 14;
  localparam int STAT_W  = 3;
  localparam int WDAY_W  = 3;
  localparam int POS_W   = 4;

  // text layout
  localparam logic [POS_W-1:0] POS_MONTH = 4'd2;   // first separator
  localparam logic [POS_W-1:0] POS_YEAR  = 4'd5;   // second separator
  localparam logic [POS_W-1:0] POS_LEN   = 4'd10;  // full text length
  localparam logic [POS_W-1:0] POS_SAT   = 4'd11;  // count saturates here

  localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'd48;
  localparam logic [CHAR_W-1:0] CHAR_NINE = 8'd57;

  // reciprocal constants for the constant divisors
  localparam int Q100_W      = 8;
  localparam int RECIP_100   = 41944;  // ceil(2^22 / 100)
  localparam int RECIP_100_SH = 22;
  localparam int SUM_W       = 15;
  localparam int Q7_W        = 13;
  localparam int RECIP_7     = 37450;  // ceil(2^18 / 7)
  localparam int RECIP_7_SH  = 18;

  // status codes
  localparam logic [STAT_W-1:0] STAT_OK     = 3'd0;
  localparam logic [STAT_W-1:0] STAT_FORMAT = 3'd1;
  localparam logic [STAT_W-1:0] STAT_DAY    = 3'd2;
  localparam logic [STAT_W-1:0] STAT_MONTH  = 3'd3;
  localparam logic [STAT_W-1:0] STAT_YEAR   = 3'd4;

  typedef struct packed {
    logic [CHAR_W-1:0] character;
    logic              last;
  } in_item_t;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [WDAY_W-1:0]  weekday;
    logic [DAY_W-1:0]   day;
    logic [MONTH_W-1:0] month;
    logic [YEAR_W-1:0]  year;
  } out_item_t;

  // finished text, raw fields
  typedef struct packed {
    logic [DAY_W-1:0]   day;
    logic [MONTH_W-1:0] month;
    logic [YEAR_W-1:0]  year;
    logic               bad;
  } stage1_t;

  // plus march-based year and month, year / 100
  typedef struct packed {
    logic [DAY_W-1:0]   day;
    logic [MONTH_W-1:0] month;
    logic [YEAR_W-1:0]  year;
    logic               bad;
    logic [YEAR_W-1:0]  year_adj;
    logic [3:0]         month_adj;
    logic [Q100_W-1:0]  q100;
  } stage2_t;

  // status decided, weekday sum before mod 7
  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [DAY_W-1:0]   day;
    logic [MONTH_W-1:0] month;
    logic [YEAR_W-1:0]  year;
    logic [SUM_W-1:0]   sum;
  } stage3_t;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [DAY_W-1:0]   day;
    logic [MONTH_W-1:0] month;
    logic [YEAR_W-1:0]  year;
    logic [SUM_W-1:0]   sum;
    logic [Q7_W-1:0]    q7;
  } stage4_t;

  // (31 * m) / 12 for march-based month 1..12
  function automatic logic [4:0] month_offset(input logic [3:0] m);
    logic [4:0] r;
    unique case (m)
      4'd1:    r = 5'd2;
      4'd2:    r = 5'd5;
      4'd3:    r = 5'd7;
      4'd4:    r = 5'd10;
      4'd5:    r = 5'd12;
      4'd6:    r = 5'd15;
      4'd7:    r = 5'd18;
      4'd8:    r = 5'd20;
      4'd9:    r = 5'd23;
      4'd10:   r = 5'd25;
      4'd11:   r = 5'd28;
      4'd12:   r = 5'd31;
      default: r = 5'd0;
    endcase
    return r;
  endfunction

  function automatic logic [4:0] month_days(input logic [MONTH_W-1:0] m,
                                            input logic leap);
    logic [4:0] r;
    unique case (m)
      7'd4, 7'd6, 7'd9, 7'd11: r = 5'd30;
      7'd2:                    r = leap ? 5'd29 : 5'd28;
      default:                 r = 5'd31;
    endcase
    return r;
  endfunction

endpackage

/* src/date_text_check_weekday_core.sv */
// date text checker: parses dd.mm.yyyy one character per item, emits status and weekday
// result path: the item that carries the last mark is registered through s1, s2, s3, s4 and then res_item
// throughput: one character item per cycle while char_stall is low; a result queue of five slots (four
//   pipeline stages plus the result register) lets input continue while results wait
// reset: synchronous, active high; clears the parse state and all valid flags,
//   no clearing pass is needed
module date_text_check_weekday_core (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  char_valid,
  output logic                  char_stall,
  input  dtcw_pkg::in_item_t    char_item,
  output logic                  res_valid,
  input  logic                  res_stall,
  output dtcw_pkg::out_item_t   res_item
);

  // parse state
  logic [dtcw_pkg::POS_W-1:0]   position, position_next;
  logic [dtcw_pkg::DAY_W-1:0]   day_acc, day_acc_next;
  logic [dtcw_pkg::MONTH_W-1:0] month_acc, month_acc_next;
  logic [dtcw_pkg::YEAR_W-1:0]  year_acc, year_acc_next;
  logic                         format_bad, format_bad_next;

  // result pipeline
  dtcw_pkg::stage1_t s1, s1_next;
  dtcw_pkg::stage2_t s2, s2_next;
  dtcw_pkg::stage3_t s3, s3_next;
  dtcw_pkg::stage4_t s4;
  dtcw_pkg::out_item_t res_next;
  logic v1, v2, v3, v4;
  logic rdy1, rdy2, rdy3, rdy4, out_rdy;
  logic accept;

  // character decode
  logic       digit_pos;
  logic       is_digit;
  logic [3:0] digit;

  // ready chain: a stage takes new data when empty or when it moves on
  assign out_rdy    = !res_valid || !res_stall;
  assign rdy4       = !v4 || out_rdy;
  assign rdy3       = !v3 || rdy4;
  assign rdy2       = !v2 || rdy3;
  assign rdy1       = !v1 || rdy2;
  assign char_stall = !rdy1;
  assign accept     = char_valid && !char_stall;

  // accumulate the digits of the current text
  always_comb begin
    digit_pos = (position < dtcw_pkg::POS_LEN) && (position != dtcw_pkg::POS_MONTH) &&
                (position != dtcw_pkg::POS_YEAR);
    is_digit  = (char_item.character >= dtcw_pkg::CHAR_ZERO) &&
                (char_item.character <= dtcw_pkg::CHAR_NINE);
    digit     = 4'(char_item.character - dtcw_pkg::CHAR_ZERO);

    day_acc_next    = day_acc;
    month_acc_next  = month_acc;
    year_acc_next   = year_acc;
    format_bad_next = format_bad | (digit_pos & !is_digit);
    if (digit_pos && is_digit) begin
      if (position < dtcw_pkg::POS_MONTH) begin
        day_acc_next = 7'(11'(day_acc) * 11'd10 + 11'(digit));
      end else if (position < dtcw_pkg::POS_YEAR) begin
        month_acc_next = 7'(11'(month_acc) * 11'd10 + 11'(digit));
      end else begin
        year_acc_next = 14'(18'(year_acc) * 18'd10 + 18'(digit));
      end
    end
    // count saturates so that overlong texts still read as bad length
    position_next = (position < dtcw_pkg::POS_SAT) ? position + 4'd1 : position;

    s1_next.day   = day_acc_next;
    s1_next.month = month_acc_next;
    s1_next.year  = year_acc_next;
    s1_next.bad   = (position_next != dtcw_pkg::POS_LEN) || format_bad_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position   <= '0;
      day_acc    <= '0;
      month_acc  <= '0;
      year_acc   <= '0;
      format_bad <= 1'b0;
    end else if (accept) begin
      if (char_item.last) begin
        // text done, start clean for the next one
        position   <= '0;
        day_acc    <= '0;
        month_acc  <= '0;
        year_acc   <= '0;
        format_bad <= 1'b0;
      end else begin
        position   <= position_next;
        day_acc    <= day_acc_next;
        month_acc  <= month_acc_next;
        year_acc   <= year_acc_next;
        format_bad <= format_bad_next;
      end
    end
  end

  // stage 1 -> 2: shift to a march-based year, divide year by 100
  logic                        s1_early;
  logic [29:0]                 prod100;
  always_comb begin
    s1_early           = s1.month <= 7'd2;
    s2_next.day        = s1.day;
    s2_next.month      = s1.month;
    s2_next.year       = s1.year;
    s2_next.bad        = s1.bad;
    // january and february count as months of the previous year
    s2_next.year_adj   = s1_early ? s1.year - 14'd1 : s1.year;
    s2_next.month_adj  = s1_early ? 4'(s1.month + 7'd10) : 4'(s1.month - 7'd2);
    prod100            = 30'(s2_next.year_adj) * 30'(dtcw_pkg::RECIP_100);
    s2_next.q100       = prod100[dtcw_pkg::RECIP_100_SH +: dtcw_pkg::Q100_W];
  end

  // stage 2 -> 3: leap year, range checks, weekday sum
  logic                  s2_early;
  logic [13:0]           hundreds;
  logic [6:0]            rem100;
  logic                  cent;
  logic [8:0]            cent_q;
  logic                  leap;
  logic [4:0]            mdays;
  logic [15:0]           wsum;
  always_comb begin
    s2_early = s2.month <= 7'd2;
    hundreds = 14'(s2.q100) * 14'd100;
    rem100   = 7'(s2.year_adj - hundreds);
    // the real year is one more than the adjusted one in january and february
    cent     = s2_early ? (rem100 == 7'd99) : (rem100 == 7'd0);
    cent_q   = 9'(s2.q100) + ((s2_early && rem100 == 7'd99) ? 9'd1 : 9'd0);
    leap     = ((s2.year[1:0] == 2'b00) && !cent) || (cent && cent_q[1:0] == 2'b00);
    mdays    = dtcw_pkg::month_days(s2.month, leap);

    if (s2.bad) begin
      s3_next.status = dtcw_pkg::STAT_FORMAT;
    end else if (s2.month < 7'd1 || s2.month > 7'd12) begin
      s3_next.status = dtcw_pkg::STAT_MONTH;
    end else if (s2.day < 7'd1 || s2.day > 7'(mdays)) begin
      s3_next.status = dtcw_pkg::STAT_DAY;
    end else if (s2.year == '0) begin
      s3_next.status = dtcw_pkg::STAT_YEAR;
    end else begin
      s3_next.status = dtcw_pkg::STAT_OK;
    end

    // bad format reports zero fields
    s3_next.day   = s2.bad ? '0 : s2.day;
    s3_next.month = s2.bad ? '0 : s2.month;
    s3_next.year  = s2.bad ? '0 : s2.year;

    // d + 31m/12 + y + y/4 - y/100 + y/400, only meaningful when status is ok
    wsum = 16'(s2.day) + 16'(dtcw_pkg::month_offset(s2.month_adj)) + 16'(s2.year_adj) +
           16'(s2.year_adj >> 2) - 16'(s2.q100) + 16'(s2.q100 >> 2);
    s3_next.sum = wsum[dtcw_pkg::SUM_W-1:0];
  end

  // stage 3 -> 4: sum / 7 by reciprocal
  logic [30:0] prod7;
  assign prod7 = 31'(s3.sum) * 31'(dtcw_pkg::RECIP_7);

  // stage 4 -> result: remainder mod 7
  logic [dtcw_pkg::SUM_W-1:0] rem7;
  always_comb begin
    rem7             = s4.sum - dtcw_pkg::SUM_W'(s4.q7) * dtcw_pkg::SUM_W'(7);
    res_next.status  = s4.status;
    res_next.weekday = (s4.status == dtcw_pkg::STAT_OK) ? rem7[2:0] : '0;
    res_next.day     = s4.day;
    res_next.month   = s4.month;
    res_next.year    = s4.year;
  end

  // pipeline valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      if (rdy1)    v1        <= accept && char_item.last;
      if (rdy2)    v2        <= v1;
      if (rdy3)    v3        <= v2;
      if (rdy4)    v4        <= v3;
      if (out_rdy) res_valid <= v4;
    end
  end

  // pipeline payload, no reset needed
  always_ff @(posedge clk) begin
    if (rdy1 && accept && char_item.last) s1 <= s1_next;
    if (rdy2 && v1) s2 <= s2_next;
    if (rdy3 && v2) s3 <= s3_next;
    if (rdy4 && v3) begin
      s4.status <= s3.status;
      s4.day    <= s3.day;
      s4.month  <= s3.month;
      s4.year   <= s3.year;
      s4.sum    <= s3.sum;
      s4.q7     <= prod7[dtcw_pkg::RECIP_7_SH +: dtcw_pkg::Q7_W];
    end
    if (out_rdy && v4) res_item <= res_next;
  end

endmodule

/* src/dtcw_checker.sv */
// port-level checks for the date text checker, bound to the top level
module dtcw_checker (
  input logic                clk,
  input logic                rst,
  input logic                char_valid,
  input logic                char_stall,
  input dtcw_pkg::in_item_t  char_item,
  input logic                res_valid,
  input logic                res_stall,
  input dtcw_pkg::out_item_t res_item
);

  // a stalled result holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res_item))
    else $error("stalled result changed");

  // no result right after reset
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid after reset");

  // weekday only on success
  a_wday_err: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_item.status != dtcw_pkg::STAT_OK |-> res_item.weekday == '0)
    else $error("weekday set on error");

  // bad format clears the fields
  a_fmt_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_item.status == dtcw_pkg::STAT_FORMAT |->
      res_item.day == '0 && res_item.month == '0 && res_item.year == '0)
    else $error("fields not cleared on bad format");

  // success means a plausible date
  a_ok_range: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_item.status == dtcw_pkg::STAT_OK |->
      res_item.month >= 7'd1 && res_item.month <= 7'd12 && res_item.day >= 7'd1 &&
      res_item.day <= 7'd31 && res_item.year != '0 && res_item.weekday <= 3'd6)
    else $error("ok status with impossible date");

endmodule

bind date_text_check_weekday_core dtcw_checker u_dtcw_checker (.*);
